>>> hdl/aik_pkg.sv
`default_nettype none
package aik_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CD_CELLS      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int SQ_CELLS      = 16;
  localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;

  typedef enum logic [2:0] {
    REG_GOODS_OFF_X  = 3'd0,
    REG_GOODS_OFF_Y  = 3'd1,
    REG_GOODS_OFF_Z  = 3'd2,
    REG_LOCKER_OFF_X = 3'd3,
    REG_LOCKER_OFF_Z = 3'd4,
    REG_WHEEL_TO_Z   = 3'd5,
    REG_ECCENTRICITY = 3'd6,
    REG_LENGTH       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [10:0] goods_off_x;
    logic signed [10:0] goods_off_y;
    logic signed [10:0] goods_off_z;
    logic signed [10:0] locker_off_x;
    logic signed [10:0] locker_off_z;
    logic signed [10:0] wheel_to_z_off;
    logic [9:0]         radial_eccentricity;
    logic [11:0]        radial_length;
  } cfg_t;

  typedef struct packed {
    logic               unreach;
    logic signed [12:0] wheel;
    logic signed [11:0] gz;
    logic signed [11:0] lz;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] v;
    logic [15:0] root;
    logic [16:0] rem;
  } sq_t;

  typedef struct packed {
    side_t              side;
    logic signed [25:0] x;
    logic signed [25:0] y;
    logic signed [22:0] z;
    logic [4:0]         idx;
    logic               zero;
    logic [14:0]        l16;
  } cd_t;

  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] r;
    case (i)
      5'd0:  r = 20'd823550;
      5'd1:  r = 20'd486170;
      5'd2:  r = 20'd256879;
      5'd3:  r = 20'd130396;
      5'd4:  r = 20'd65451;
      5'd5:  r = 20'd32757;
      5'd6:  r = 20'd16383;
      5'd7:  r = 20'd8192;
      5'd8:  r = 20'd4096;
      5'd9:  r = 20'd2048;
      5'd10: r = 20'd1024;
      5'd11: r = 20'd512;
      5'd12: r = 20'd256;
      5'd13: r = 20'd128;
      5'd14: r = 20'd64;
      5'd15: r = 20'd32;
      5'd16: r = 20'd16;
      5'd17: r = 20'd8;
      5'd18: r = 20'd4;
      5'd19: r = 20'd2;
      5'd20: r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/aik_prep.sv
`default_nettype none
module aik_prep
  import aik_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] gx_raw,
  input  wire logic [7:0] gy_raw,
  input  wire logic [7:0] gz_raw,
  input  wire logic [7:0] lx_raw,
  input  wire logic [7:0] lz_raw,
  output logic            out_valid,
  input  wire logic       out_ready,
  output sq_t             out_data
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic signed [11:0] gx_r, gy_r;
  side_t side1_r, side2_r;
  logic [21:0] gx2_r, gy2_r;
  logic [19:0] ee_r;
  sq_t data3_r;

  logic signed [11:0] gx_nxt, gy_nxt;
  side_t side1_nxt;
  logic signed [23:0] gx2_full, gy2_full;
  logic [19:0] ee_full;
  logic signed [23:0] rad;
  sq_t data3_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    gx_nxt = $signed({4'b0000, gx_raw}) + {cfg.goods_off_x[10], cfg.goods_off_x};
    gy_nxt = $signed({4'b0000, gy_raw}) + {cfg.goods_off_y[10], cfg.goods_off_y};
    side1_nxt.unreach = 1'b0;
    side1_nxt.gz = $signed({4'b0000, gz_raw}) + {cfg.goods_off_z[10], cfg.goods_off_z};
    side1_nxt.lz = $signed({4'b0000, lz_raw}) + {cfg.locker_off_z[10], cfg.locker_off_z};
    side1_nxt.wheel = $signed({5'b00000, lx_raw})
                    + {{2{cfg.locker_off_x[10]}}, cfg.locker_off_x}
                    - {{2{cfg.wheel_to_z_off[10]}}, cfg.wheel_to_z_off};
  end

  assign gx2_full = 24'(gx_r) * 24'(gx_r);
  assign gy2_full = 24'(gy_r) * 24'(gy_r);
  assign ee_full  = 20'(cfg.radial_eccentricity) * 20'(cfg.radial_eccentricity);

  always_comb begin
    rad = $signed({2'b00, gx2_r}) + $signed({2'b00, gy2_r}) - $signed({4'b0000, ee_r});
    data3_nxt.side = side2_r;
    data3_nxt.side.unreach = rad[23];
    data3_nxt.v = rad[23] ? 32'd0 : {rad[21:0], 10'd0};
    data3_nxt.root = '0;
    data3_nxt.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      gx_r    <= gx_nxt;
      gy_r    <= gy_nxt;
      side1_r <= side1_nxt;
    end
    if (rdy2 && v1_r) begin
      gx2_r   <= gx2_full[21:0];
      gy2_r   <= gy2_full[21:0];
      ee_r    <= ee_full;
      side2_r <= side1_r;
    end
    if (rdy3 && v2_r) data3_r <= data3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = data3_r;

endmodule
`default_nettype wire

>>> hdl/aik_sqrt_cell.sv
`default_nettype none
module aik_sqrt_cell
  import aik_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sq_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output sq_t       out_data
);

  logic valid_r;
  sq_t  data_r, data_nxt;
  logic [18:0] acc;
  logic [17:0] trial;

  assign in_ready = !valid_r || out_ready;

  // one root bit per cell, restoring
  always_comb begin
    acc = {in_data.rem, in_data.v[31:30]};
    trial = {in_data.root, 2'b01};
    data_nxt = in_data;
    data_nxt.v = {in_data.v[29:0], 2'b00};
    if (acc >= {1'b0, trial}) begin
      data_nxt.rem  = 17'(acc - {1'b0, trial});
      data_nxt.root = {in_data.root[14:0], 1'b1};
    end else begin
      data_nxt.rem  = acc[16:0];
      data_nxt.root = {in_data.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_ready) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

>>> hdl/aik_cordic_cell.sv
`default_nettype none
module aik_cordic_cell
  import aik_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cd_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output cd_t       out_data
);

  logic valid_r;
  cd_t  data_r, data_nxt;
  logic signed [25:0] dx, dy;
  logic signed [22:0] at;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    dx = in_data.y >>> in_data.idx;
    dy = in_data.x >>> in_data.idx;
    at = $signed({3'b000, atan_q20(in_data.idx)});
    data_nxt = in_data;
    data_nxt.idx = in_data.idx + 5'd1;
    if (in_data.y > 26'sd0) begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + at;
    end else begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_ready) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

>>> hdl/polar_arm_inverse_kinematics.sv
// Throughput: one request per cycle while the output is not stalled;
// every stage is a registered cell with its own valid, so a stalled
// output only stops the cells that are full.
// Reset (rst_n low, synchronous) clears all valids and sets every
// configuration register to zero.
`default_nettype none
module polar_arm_inverse_kinematics
  import aik_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_goods_x_raw,
  input  wire logic [7:0]  in_goods_y_raw,
  input  wire logic [7:0]  in_goods_z_raw,
  input  wire logic [7:0]  in_locker_x_raw,
  input  wire logic [7:0]  in_locker_z_raw,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [12:0] out_wheel_target,
  output logic signed [11:0] out_z_to_goods,
  output logic signed [11:0] out_z_to_locker,
  output logic signed [16:0] out_radial_target,
  output logic signed [15:0] out_theta_target,
  output logic             out_unreachable
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GOODS_OFF_X:  cfg_r.goods_off_x         <= cfg_data[10:0];
        REG_GOODS_OFF_Y:  cfg_r.goods_off_y         <= cfg_data[10:0];
        REG_GOODS_OFF_Z:  cfg_r.goods_off_z         <= cfg_data[10:0];
        REG_LOCKER_OFF_X: cfg_r.locker_off_x        <= cfg_data[10:0];
        REG_LOCKER_OFF_Z: cfg_r.locker_off_z        <= cfg_data[10:0];
        REG_WHEEL_TO_Z:   cfg_r.wheel_to_z_off      <= cfg_data[10:0];
        REG_ECCENTRICITY: cfg_r.radial_eccentricity <= cfg_data[9:0];
        REG_LENGTH:       cfg_r.radial_length       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic sq_vld [SQ_CELLS+1];
  logic sq_rdy [SQ_CELLS+1];
  sq_t  sq_dat [SQ_CELLS+1];
  logic cd_vld [CD_CELLS+1];
  logic cd_rdy [CD_CELLS+1];
  cd_t  cd_dat [CD_CELLS+1];

  aik_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .gx_raw   (in_goods_x_raw),
    .gy_raw   (in_goods_y_raw),
    .gz_raw   (in_goods_z_raw),
    .lx_raw   (in_locker_x_raw),
    .lz_raw   (in_locker_z_raw),
    .out_valid(sq_vld[0]),
    .out_ready(sq_rdy[0]),
    .out_data (sq_dat[0])
  );

  genvar g;
  generate
    for (g = 0; g < SQ_CELLS; g++) begin : g_sq
      aik_sqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_vld[g]),
        .in_ready (sq_rdy[g]),
        .in_data  (sq_dat[g]),
        .out_valid(sq_vld[g+1]),
        .out_ready(sq_rdy[g+1]),
        .out_data (sq_dat[g+1])
      );
    end
  endgenerate

  // rounded reach in 1/16 mm, then CORDIC seed
  logic [16:0] root_p1;
  logic [14:0] l16;

  assign root_p1 = {1'b0, sq_dat[SQ_CELLS].root} + 17'd1;
  assign l16     = root_p1[15:1];

  always_comb begin
    cd_dat[0].side = sq_dat[SQ_CELLS].side;
    cd_dat[0].x    = $signed({4'b0000, cfg_r.radial_eccentricity, 12'd0});
    cd_dat[0].y    = $signed({3'b000, l16, 8'd0});
    cd_dat[0].z    = '0;
    cd_dat[0].idx  = '0;
    cd_dat[0].zero = (l16 == 15'd0);
    cd_dat[0].l16  = l16;
  end
  assign cd_vld[0]        = sq_vld[SQ_CELLS];
  assign sq_rdy[SQ_CELLS] = cd_rdy[0];

  generate
    for (g = 0; g < CD_CELLS; g++) begin : g_cd
      aik_cordic_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cd_vld[g]),
        .in_ready (cd_rdy[g]),
        .in_data  (cd_dat[g]),
        .out_valid(cd_vld[g+1]),
        .out_ready(cd_rdy[g+1]),
        .out_data (cd_dat[g+1])
      );
    end
  endgenerate

  logic out_valid_r;
  logic signed [12:0] wheel_r;
  logic signed [11:0] gz_r, lz_r;
  logic signed [16:0] radial_r;
  logic signed [15:0] theta_r;
  logic unreach_r;

  logic signed [22:0] z_fin;
  logic signed [23:0] theta20;
  logic signed [23:0] theta_sh;
  logic signed [17:0] radial_full;
  logic fin_rdy;
  cd_t  fin;

  assign fin     = cd_dat[CD_CELLS];
  assign fin_rdy = !out_valid_r || out_ready;
  assign cd_rdy[CD_CELLS] = fin_rdy;

  always_comb begin
    z_fin       = fin.zero ? 23'sd0 : fin.z;
    theta20     = HALF_PI_Q20 - {z_fin[22], z_fin} + 24'sd32;
    theta_sh    = theta20 >>> 6;
    radial_full = $signed({2'b00, cfg_r.radial_length, 4'd0})
                - $signed({3'b000, fin.l16});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (fin_rdy) out_valid_r <= cd_vld[CD_CELLS];
  end

  always_ff @(posedge clk) begin
    if (fin_rdy && cd_vld[CD_CELLS]) begin
      wheel_r   <= fin.side.wheel;
      gz_r      <= fin.side.gz;
      lz_r      <= fin.side.lz;
      unreach_r <= fin.side.unreach;
      radial_r  <= radial_full[16:0];
      theta_r   <= theta_sh[15:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wheel_target  = wheel_r;
  assign out_z_to_goods    = gz_r;
  assign out_z_to_locker   = lz_r;
  assign out_radial_target = radial_r;
  assign out_theta_target  = theta_r;
  assign out_unreachable   = unreach_r;

endmodule
`default_nettype wire
